// File: rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int TAB_STEP_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0]  ATTR_RESET  = 8'h0F;
    localparam logic [7:0]  SPACE_CODE  = 8'h20;
    localparam logic [7:0]  BS_CODE     = 8'h08;
    localparam logic [7:0]  TAB_CODE    = 8'h09;
    localparam logic [7:0]  LF_CODE     = 8'h0A;
    localparam logic [7:0]  CR_CODE     = 8'h0D;
    localparam logic [15:0] RESET_CELL  = {ATTR_RESET, SPACE_CODE};

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_PRINT = 3'd1;
    localparam logic [2:0] OP_BS    = 3'd2;
    localparam logic [2:0] OP_TAB   = 3'd3;
    localparam logic [2:0] OP_CR    = 3'd4;
    localparam logic [2:0] OP_LF    = 3'd5;
    localparam logic [2:0] OP_CLEAR = 3'd6;
    localparam logic [2:0] OP_READ  = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_item;

    typedef struct packed {
        logic [10:0] cursor_index;
        logic [15:0] cell_data;
        logic        scrolled;
    } t_result;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  code;
        logic [10:0] cell_index;
    } t_cmd;

endpackage

// File: rtl/tcw_front.sv
module tcw_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tcw_pkg::t_item i_item,
    input  logic           i_hold,
    input  logic           i_q_full,
    output logic           o_busy,
    output logic           o_push,
    output tcw_pkg::t_cmd  o_cmd
);

    logic          r_vld;
    logic          n_vld;
    tcw_pkg::t_cmd r_cmd;
    tcw_pkg::t_cmd n_cmd;
    logic          accept;

    assign o_busy = i_hold | (r_vld & i_q_full);
    assign o_push = r_vld & ~i_q_full;
    assign o_cmd  = r_cmd;
    assign accept = i_start & ~o_busy;

    // Decode the beat into one back-end operation.
    always_comb begin
        n_cmd            = r_cmd;
        n_vld            = r_vld & ~o_push;
        if (accept) begin
            n_vld            = 1'b1;
            n_cmd.code       = i_item.char_code[6:0];
            n_cmd.cell_index = i_item.cell_index;
            case (i_item.func)
                tcw_pkg::FUNC_PUT: begin
                    if (i_item.char_code == tcw_pkg::BS_CODE) begin
                        n_cmd.op = tcw_pkg::OP_BS;
                    end else if (i_item.char_code == tcw_pkg::TAB_CODE) begin
                        n_cmd.op = tcw_pkg::OP_TAB;
                    end else if (i_item.char_code == tcw_pkg::CR_CODE) begin
                        n_cmd.op = tcw_pkg::OP_CR;
                    end else if (i_item.char_code == tcw_pkg::LF_CODE) begin
                        n_cmd.op = tcw_pkg::OP_LF;
                    end else if (i_item.char_code >= tcw_pkg::SPACE_CODE
                                 && !i_item.char_code[7]) begin
                        n_cmd.op = tcw_pkg::OP_PRINT;
                    end else begin
                        n_cmd.op = tcw_pkg::OP_NOP;
                    end
                end
                tcw_pkg::FUNC_CLEAR: n_cmd.op = tcw_pkg::OP_CLEAR;
                tcw_pkg::FUNC_READ:  n_cmd.op = tcw_pkg::OP_READ;
                default:             n_cmd.op = tcw_pkg::OP_NOP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_cmd <= n_cmd;
    end

endmodule

// File: rtl/tcw_queue.sv
module tcw_queue #(
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_vld,
    output tcw_pkg::t_cmd o_rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    tcw_pkg::t_cmd    r_entries [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_rdata = r_entries[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_entries[r_wp] <= i_wdata;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_vld)
        else $error("pop from an empty queue");
`endif

endmodule

// File: rtl/tcw_back.sv
module tcw_back #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_attr,
    input  logic             i_q_vld,
    input  tcw_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_init,
    output logic             o_done,
    output tcw_pkg::t_result o_result
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS + TAB_STEP + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int PW    = $clog2(TAB_STEP);

    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
    localparam logic [LW-1:0] LAST_BASE = LW'((ROWS - 1) * COLUMNS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [PW-1:0] PH_LAST   = PW'(TAB_STEP - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDWAIT = 3'd1;
    localparam logic [2:0] ST_PRIME  = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;

    logic [15:0]      r_mem [CELLS];
    logic [15:0]      r_rdata;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [LW-1:0]    r_base, n_base;
    logic [PW-1:0]    r_phase, n_phase;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_src, n_src;
    logic             r_rd_ok, n_rd_ok;
    logic             r_emit, n_emit;
    logic             r_scr, n_scr;
    logic             r_done, n_done;
    tcw_pkg::t_result r_res, n_res;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [15:0]      mem_wd;
    logic [AW-1:0]    mem_ra;
    logic [15:0]      blank;
    logic [CW-1:0]    col_step;
    logic [PW-1:0]    phase_step;
    logic             line_step;
    logic [LW-1:0]    base_step;

    assign o_init   = (r_state == ST_FILL) && !r_emit;
    assign o_done   = r_done;
    assign o_result = r_res;
    assign blank    = r_emit ? {i_attr, tcw_pkg::SPACE_CODE} : tcw_pkg::RESET_CELL;

    // Cursor motion for the operation at the head of the queue. The tab
    // phase tracks the column modulo the tab step.
    always_comb begin
        col_step   = r_col;
        phase_step = r_phase;
        line_step  = 1'b0;
        case (i_cmd.op)
            tcw_pkg::OP_PRINT: begin
                col_step   = r_col + 1'b1;
                phase_step = (r_phase == PH_LAST) ? '0 : r_phase + 1'b1;
            end
            tcw_pkg::OP_BS: begin
                if (r_col != '0) begin
                    col_step   = r_col - 1'b1;
                    phase_step = (r_phase == '0) ? PH_LAST : r_phase - 1'b1;
                end
            end
            tcw_pkg::OP_TAB: begin
                col_step   = r_col + (CW'(TAB_STEP) - CW'(r_phase));
                phase_step = '0;
            end
            tcw_pkg::OP_CR: begin
                col_step   = '0;
                phase_step = '0;
            end
            tcw_pkg::OP_LF: begin
                col_step   = '0;
                phase_step = '0;
                line_step  = 1'b1;
            end
            default: ;
        endcase
        if (col_step >= CW'(COLUMNS)) begin
            col_step   = '0;
            phase_step = '0;
            line_step  = 1'b1;
        end
        base_step = line_step ? r_base + LW'(COLUMNS) : r_base;
    end

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_base  = r_base;
        n_phase = r_phase;
        n_ptr   = r_ptr;
        n_src   = r_src;
        n_rd_ok = r_rd_ok;
        n_emit  = r_emit;
        n_scr   = r_scr;
        n_done  = 1'b0;
        n_res   = r_res;
        mem_we  = 1'b0;
        mem_wa  = r_ptr;
        mem_wd  = blank;
        mem_ra  = r_src;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_vld) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        tcw_pkg::OP_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_base  = '0;
                            n_phase = '0;
                            n_ptr   = '0;
                            n_emit  = 1'b1;
                            n_scr   = 1'b0;
                            n_state = ST_FILL;
                        end
                        tcw_pkg::OP_READ: begin
                            mem_ra  = AW'(i_cmd.cell_index);
                            n_rd_ok = (32'(i_cmd.cell_index) < CELLS);
                            n_state = ST_RDWAIT;
                        end
                        default: begin
                            if (i_cmd.op == tcw_pkg::OP_PRINT) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(r_base + LW'(r_col));
                                mem_wd = {i_attr, 1'b0, i_cmd.code};
                            end
                            n_col   = col_step;
                            n_phase = phase_step;
                            if (line_step && r_row == ROW_LAST) begin
                                // Cursor fell off the bottom: scroll first,
                                // report when the walk finishes.
                                n_row   = ROW_LAST;
                                n_base  = LAST_BASE;
                                n_emit  = 1'b1;
                                n_scr   = 1'b1;
                                n_state = ST_PRIME;
                            end else begin
                                n_row  = r_row + RW'(line_step);
                                n_base = base_step;
                                n_done = 1'b1;
                                n_res.cursor_index = 11'(base_step + LW'(col_step));
                                n_res.cell_data    = 16'h0000;
                                n_res.scrolled     = 1'b0;
                            end
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                n_done  = 1'b1;
                n_res.cursor_index = 11'(r_base + LW'(r_col));
                n_res.cell_data    = r_rd_ok ? r_rdata : 16'h0000;
                n_res.scrolled     = 1'b0;
                n_state = ST_IDLE;
            end
            ST_PRIME: begin
                mem_ra  = AW'(COLUMNS);
                n_src   = AW'(COLUMNS + 1);
                n_ptr   = '0;
                n_state = ST_SCROLL;
            end
            ST_SCROLL, ST_FILL: begin
                mem_we = 1'b1;
                if (r_state == ST_SCROLL && r_ptr < COPY_END) begin
                    mem_wd = r_rdata;
                end
                if (r_src != CELL_LAST) begin
                    n_src = r_src + 1'b1;
                end
                if (r_ptr == CELL_LAST) begin
                    n_state = ST_IDLE;
                    n_done  = r_emit;
                    n_res.cursor_index = 11'(r_base + LW'(r_col));
                    n_res.cell_data    = 16'h0000;
                    n_res.scrolled     = r_scr;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_phase <= '0;
            r_ptr   <= '0;
            r_emit  <= 1'b0;
            r_scr   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_base  <= n_base;
            r_phase <= n_phase;
            r_ptr   <= n_ptr;
            r_emit  <= n_emit;
            r_scr   <= n_scr;
            r_done  <= n_done;
        end
        r_src   <= n_src;
        r_rd_ok <= n_rd_ok;
        r_res   <= n_res;
    end

`ifndef SYNTHESIS
    a_read_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWAIT) |=> r_done)
        else $error("read finished without a result beat");
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.scrolled) |-> (r_row == ROW_LAST && r_col == '0))
        else $error("scroll left the cursor off the start of the last row");
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_col < CW'(COLUMNS) && r_row <= ROW_LAST))
        else $error("cursor out of the screen while idle");
`endif

endmodule

// File: rtl/text_console_writer_core.sv
// Channel   Direction  Handshake              Beat
// item      in         start high, busy low   i_item (func, char_code, cell_index)
// result    out        o_done for one cycle   o_result (cursor_index, cell_data, scrolled)
// attribute in         i_attr_we              i_attr_wdata
//
// A put ends in the back end's idle state, a read in ST_RDWAIT (registered memory port).
// Clear walks all ROWS*COLUMNS cells one per cycle; a scroll walks them once
// after a priming state for the copy read, all through the single screen RAM.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with busy high.
// busy also rises when the decode stage and the command queue are both full.
// Results cannot be held off; o_done marks each result beat.
module text_console_writer_core #(
    parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS        = tcw_pkg::ROWS_DEF,
    parameter int TAB_STEP    = tcw_pkg::TAB_STEP_DEF,
    parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tcw_pkg::t_item   i_item,
    output logic             o_done,
    output tcw_pkg::t_result o_result,
    input  logic             i_attr_we,
    input  logic [7:0]       i_attr_wdata
);

    logic [7:0]    r_attr;
    logic          init;
    logic          q_full;
    logic          q_vld;
    logic          push;
    logic          pop;
    tcw_pkg::t_cmd front_cmd;
    tcw_pkg::t_cmd head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_attr_we) begin
            r_attr <= i_attr_wdata;
        end
    end

    tcw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_hold   (init),
        .i_q_full (q_full),
        .o_busy   (busy),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    tcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_rdata (head_cmd)
    );

    tcw_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_attr   (r_attr),
        .i_q_vld  (q_vld),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_init   (init),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
